// ===== rtl/core/pctc_pkg.sv =====
`default_nettype none

package pctc_pkg;

    // Field widths of the item and result channels.
    localparam int KIND_W  = 3;
    localparam int PIN_W   = 16;
    localparam int COUNT_W = 11;
    localparam int TS_W    = 32;
    localparam int GEN_W   = 32;
    localparam int CAUSE_W = 2;
    localparam int RKIND_W = 3;

    // Configuration port geometry.
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Largest number of edges one run can record.
    localparam int CAPACITY = 1024;

    // Register reset values.
    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(CAPACITY);
    localparam logic [PIN_W-1:0]   MASK_RESET  = PIN_W'((1 << 1) | (1 << 2) | (1 << 3) |
                                                        (1 << 5) | (1 << 14) | (1 << 15));

    // Register index, taken from the word address.
    typedef enum logic {
        REG_EDGE_QUOTA = 1'b0,
        REG_PIN_SELECT = 1'b1
    } reg_idx_t;

    // Input item kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE     = 3'd0,
        KIND_ARM        = 3'd1,
        KIND_HOST_STOP  = 3'd2,
        KIND_FORCE_SAFE = 3'd3,
        KIND_CLEAR      = 3'd4
    } kind_t;

    // Result item kinds.
    typedef enum logic [RKIND_W-1:0] {
        RES_EDGE     = 3'd0,
        RES_STARTED  = 3'd1,
        RES_STOPPED  = 3'd2,
        RES_ACCEPTED = 3'd3,
        RES_REJECTED = 3'd4
    } rkind_t;

    // Reasons a run ended.
    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_LIMIT = 2'd1,
        CAUSE_HOST  = 2'd2,
        CAUSE_FORCE = 2'd3
    } cause_t;

    // Live configuration.
    typedef struct packed {
        logic [COUNT_W-1:0] edge_quota;
        logic [PIN_W-1:0]   pin_select;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic               last;
        rkind_t             result_kind;
        logic [TS_W-1:0]    timestamp;
        logic [PIN_W-1:0]   masked_pins;
        logic [COUNT_W-1:0] record_count;
        cause_t             stop_cause;
        logic               busy_res;
        logic [GEN_W-1:0]   generation_number;
    } result_t;

    // Results handed from the capture logic to the result buffer.
    typedef struct packed {
        logic        load;
        logic [1:0]  count;
        result_t     first;
        result_t     second;
    } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/pctc_in_if.sv =====
`default_nettype none

interface pctc_in_if import pctc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [PIN_W-1:0]  pins;

    modport source (output valid, output kind, output pins, input ready);
    modport sink (input valid, input kind, input pins, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/pctc_out_if.sv =====
`default_nettype none

interface pctc_out_if import pctc_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               last;
    logic [RKIND_W-1:0] result_kind;
    logic [TS_W-1:0]    timestamp;
    logic [PIN_W-1:0]   masked_pins;
    logic [COUNT_W-1:0] record_count;
    logic [CAUSE_W-1:0] stop_cause;
    logic               busy_res;
    logic [GEN_W-1:0]   generation_number;

    modport source (
        output valid, output last, output result_kind, output timestamp,
        output masked_pins, output record_count, output stop_cause,
        output busy_res, output generation_number, input ready
    );
    modport sink (
        input valid, input last, input result_kind, input timestamp,
        input masked_pins, input record_count, input stop_cause,
        input busy_res, input generation_number, output ready
    );

endinterface

`default_nettype wire

// ===== rtl/core/pctc_regs.sv =====
`default_nettype none

module pctc_regs import pctc_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [COUNT_W-1:0] limit_reg;
    logic [PIN_W-1:0]   mask_reg;
    logic               wr_en;
    reg_idx_t           idx;

    // Registers sit on word addresses; the low address bits are ignored.
    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            mask_reg  <= MASK_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_EDGE_QUOTA: limit_reg <= pwdata[COUNT_W-1:0];
                REG_PIN_SELECT: mask_reg  <= pwdata[PIN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (idx)
            REG_EDGE_QUOTA: prdata = APB_DW'(limit_reg);
            REG_PIN_SELECT: prdata = APB_DW'(mask_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.edge_quota = limit_reg;
    assign cfg.pin_select = mask_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pctc_result_buf.sv =====
`default_nettype none

module pctc_result_buf import pctc_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  push_t      push,
    output logic       free,
    pctc_out_if.source out_ch
);

    result_t    slot0_reg;
    result_t    slot1_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign out_ch.valid = (cnt_reg != 2'd0);
    assign pop          = out_ch.valid && out_ch.ready;

    // New results may enter once everything held has been taken.
    assign free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ch.ready);

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (push.load)
        begin
            cnt_reg <= push.count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Result slots; the second moves to the head when the head is taken.
    always_ff @(posedge clk)
    begin
        if (push.load)
        begin
            slot0_reg <= push.first;
            slot1_reg <= push.second;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    assign out_ch.last              = slot0_reg.last;
    assign out_ch.result_kind       = slot0_reg.result_kind;
    assign out_ch.timestamp         = slot0_reg.timestamp;
    assign out_ch.masked_pins       = slot0_reg.masked_pins;
    assign out_ch.record_count      = slot0_reg.record_count;
    assign out_ch.stop_cause        = slot0_reg.stop_cause;
    assign out_ch.busy_res          = slot0_reg.busy_res;
    assign out_ch.generation_number = slot0_reg.generation_number;

    // The buffer never holds more than the two results of one item.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer over-filled");

    // With two results held, only the second closes the item.
    a_last_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> (!slot0_reg.last && slot1_reg.last))
        else $error("last flag out of order in result buffer");

    // Loads only happen into a drained buffer.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        push.load |-> free)
        else $error("results loaded over pending results");

endmodule

`default_nettype wire

// ===== rtl/core/pin_change_timestamp_capture.sv =====
`default_nettype none

// Edge timestamp capture of masked input pins. Each input item passes an input register,
// is evaluated against the capture state and leaves its results (none, one or
// two) in a two-entry result buffer. One item is accepted per clock cycle as long as the
// result side keeps up; the input register can take the next item while results still wait.
// An item that reaches the event limit yields an edge record and a stop record; both enter
// the result buffer together. Sample items advance the 32-bit tick counter; commands do
// not. Registers: edge_quota at byte 0x0 and pin_select at byte 0x4; write them only while
// no item is in flight. An edge_quota of zero acts as one and values above 1024 act as 1024.

module pin_change_timestamp_capture import pctc_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    pctc_in_if.sink                in_ch,
    pctc_out_if.source             out_ch
);

    cfg_t  cfg;
    push_t push;
    logic  buf_free;

    // Input register.
    logic              s1_valid_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    logic [PIN_W-1:0]  s1_pins_reg;
    logic              consume;

    // Capture state.
    logic [TS_W-1:0]    tick_reg,    tick_next;
    logic [PIN_W-1:0]   prev_reg,    prev_next;
    logic [COUNT_W-1:0] events_reg,  events_next;
    logic               running_reg, running_next;
    logic               armed_reg,   armed_next;
    cause_t             cause_reg,   cause_next;
    logic [GEN_W-1:0]   gen_reg,     gen_next;

    // Per-item evaluation.
    logic [PIN_W-1:0]   mp;
    logic [COUNT_W-1:0] limit_eff;
    logic               busy;
    logic               limit_hit;
    logic [COUNT_W-1:0] events_inc;
    logic [1:0]         n_res;
    rkind_t             k0, k1;
    logic [COUNT_W-1:0] c0, c1;

    pctc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pctc_result_buf u_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .free   (buf_free),
        .out_ch (out_ch)
    );

    // The held item moves on once the result buffer has drained.
    assign consume     = s1_valid_reg && buf_free;
    assign in_ch.ready = !s1_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_kind_reg <= in_ch.kind;
            s1_pins_reg <= in_ch.pins;
        end
    end

    // Common terms of the evaluation.
    always_comb
    begin
        mp         = s1_pins_reg & cfg.pin_select;
        busy       = armed_reg || running_reg;
        events_inc = events_reg + COUNT_W'(1);
        if (cfg.edge_quota == '0)
        begin
            limit_eff = COUNT_W'(1);
        end
        else if (cfg.edge_quota > COUNT_W'(CAPACITY))
        begin
            limit_eff = COUNT_W'(CAPACITY);
        end
        else
        begin
            limit_eff = cfg.edge_quota;
        end
        limit_hit = ({1'b0, events_reg} + (COUNT_W + 1)'(1)) >= {1'b0, limit_eff};
    end

    // Next state and result kinds for the held item.
    always_comb
    begin
        tick_next    = tick_reg;
        prev_next    = prev_reg;
        events_next  = events_reg;
        running_next = running_reg;
        armed_next   = armed_reg;
        cause_next   = cause_reg;
        gen_next     = gen_reg;
        n_res        = 2'd0;
        k0           = RES_ACCEPTED;
        k1           = RES_ACCEPTED;
        c0           = events_reg;
        c1           = events_reg;

        case (s1_kind_reg) inside
            KIND_SAMPLE:
            begin
                tick_next = tick_reg + TS_W'(1);
                if (armed_reg)
                begin
                    // This sample is the baseline of the run.
                    armed_next   = 1'b0;
                    running_next = 1'b1;
                    prev_next    = mp;
                    events_next  = '0;
                    cause_next   = CAUSE_NONE;
                    n_res        = 2'd1;
                    k0           = RES_STARTED;
                    c0           = '0;
                end
                else if (running_reg && (mp != prev_reg))
                begin
                    events_next = events_inc;
                    prev_next   = mp;
                    k0          = RES_EDGE;
                    c0          = events_reg;
                    if (limit_hit)
                    begin
                        running_next = 1'b0;
                        cause_next   = CAUSE_LIMIT;
                        n_res        = 2'd2;
                        k1           = RES_STOPPED;
                        c1           = events_inc;
                    end
                    else
                    begin
                        n_res = 2'd1;
                    end
                end
            end
            KIND_ARM:
            begin
                n_res = 2'd1;
                if (busy)
                begin
                    k0 = RES_REJECTED;
                end
                else
                begin
                    events_next = '0;
                    cause_next  = CAUSE_NONE;
                    armed_next  = 1'b1;
                    c0          = '0;
                end
            end
            KIND_HOST_STOP, KIND_FORCE_SAFE:
            begin
                armed_next   = 1'b0;
                running_next = 1'b0;
                if (running_reg)
                begin
                    cause_next = (s1_kind_reg == KIND_HOST_STOP) ? CAUSE_HOST : CAUSE_FORCE;
                end
                else if (armed_reg && (s1_kind_reg == KIND_HOST_STOP))
                begin
                    cause_next = CAUSE_HOST;
                end
                // A stop record precedes the accept when a run or a host stop of an arm ends.
                if (running_reg || (armed_reg && (s1_kind_reg == KIND_HOST_STOP)))
                begin
                    n_res = 2'd2;
                    k0    = RES_STOPPED;
                    k1    = RES_ACCEPTED;
                end
                else
                begin
                    n_res = 2'd1;
                end
            end
            KIND_CLEAR:
            begin
                n_res = 2'd1;
                if (busy)
                begin
                    k0 = RES_REJECTED;
                end
                else
                begin
                    gen_next    = gen_reg + GEN_W'(1);
                    events_next = '0;
                    prev_next   = mp;
                    cause_next  = CAUSE_NONE;
                    c0          = '0;
                end
            end
            default:
            begin
                // Unknown kinds are dropped without effect.
            end
        endcase
    end

    // Result items carry the stop cause, busy flag and generation as they stand after the item.
    always_comb
    begin
        push.load   = consume && (n_res != 2'd0);
        push.count  = n_res;

        push.first.last              = (n_res == 2'd1);
        push.first.result_kind       = k0;
        push.first.timestamp         = tick_reg;
        push.first.masked_pins       = mp;
        push.first.record_count      = c0;
        push.first.stop_cause        = cause_next;
        push.first.busy_res          = armed_next || running_next;
        push.first.generation_number = gen_next;

        push.second                  = push.first;
        push.second.last             = 1'b1;
        push.second.result_kind      = k1;
        push.second.record_count     = c1;
    end

    // Capture state registers, updated when the held item is evaluated.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= '0;
            prev_reg    <= '0;
            events_reg  <= '0;
            running_reg <= 1'b0;
            armed_reg   <= 1'b0;
            cause_reg   <= CAUSE_NONE;
            gen_reg     <= GEN_W'(1);
        end
        else if (consume)
        begin
            tick_reg    <= tick_next;
            prev_reg    <= prev_next;
            events_reg  <= events_next;
            running_reg <= running_next;
            armed_reg   <= armed_next;
            cause_reg   <= cause_next;
            gen_reg     <= gen_next;
        end
    end

    // Armed and running exclude each other.
    a_arm_run: assert property (@(posedge clk) disable iff (!rst_n)
        !(armed_reg && running_reg))
        else $error("armed and running both set");

    // The event count never passes the capacity.
    a_events_cap: assert property (@(posedge clk) disable iff (!rst_n)
        events_reg <= COUNT_W'(CAPACITY))
        else $error("event count beyond capacity");

    // Only an evaluated sample item moves the tick counter.
    a_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(consume && (s1_kind_reg == KIND_SAMPLE)) |=> $stable(tick_reg))
        else $error("tick counter moved without a sample");

endmodule

`default_nettype wire

// ===== bench/pctc_capture_checker.sv =====
`timescale 1ns / 100ps

module pctc_capture_checker import pctc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic [APB_DW-1:0] prdata,
    pctc_in_if                in_mon,
    pctc_out_if               out_mon,
    output int                fail_count,
    output int                pending,
    output int                items_seen,
    output int                results_seen,
    output int                edges_seen,
    output int                limit_stops
);

    // Configuration as last written over the register port.
    logic [COUNT_W-1:0] limit_reg;
    logic [PIN_W-1:0]   mask_reg;
    logic [APB_DW-1:0]  read_expect;

    // Predicted capture state.
    logic [TS_W-1:0]    tick;
    logic [PIN_W-1:0]   baseline_pins;
    logic [COUNT_W-1:0] taken;
    logic               running;
    logic               armed;
    cause_t             cause;
    logic [TS_W-1:0]    last_edge_tick;
    logic [GEN_W-1:0]   generation;

    // Results predicted but not yet delivered, oldest first.
    result_t awaited_results[$];

    int errors;
    int n_items;
    int n_results;
    int n_edges;
    int n_limit_stops;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                      n_results, name, got, want));
    endtask

    // A limit of zero counts as one; anything above the capacity is clamped.
    function automatic int unsigned effective_limit();
        int unsigned lim;
        lim = 32'(limit_reg);
        if (lim == 0)
            lim = 1;
        if (lim > CAPACITY)
            lim = CAPACITY;
        return lim;
    endfunction

    // Queues one result, stamped with the state as it stands at this point.
    task automatic queue_result(input rkind_t rk, input logic [TS_W-1:0] ts,
                                input logic [PIN_W-1:0] mp, input logic [COUNT_W-1:0] cnt);
        result_t r;
        r.last              = 1'b0;
        r.result_kind       = rk;
        r.timestamp         = ts;
        r.masked_pins       = mp;
        r.record_count      = cnt;
        r.stop_cause        = cause;
        r.busy_res          = armed || running;
        r.generation_number = generation;
        awaited_results.push_back(r);
    endtask

    // Applies one accepted item to the capture state and queues its results.
    task automatic advance_capture(input logic [KIND_W-1:0] k, input logic [PIN_W-1:0] raw);
        logic [PIN_W-1:0]   mp;
        logic [TS_W-1:0]    now;
        logic [COUNT_W-1:0] idx;
        int                 before_size;
        logic               stopped;
        mp          = raw & mask_reg;
        now         = tick;
        before_size = awaited_results.size();
        stopped     = 1'b0;
        case (k) inside
            KIND_SAMPLE:
            begin
                tick = now + 1;
                if (armed)
                begin
                    // This sample only sets the baseline and starts the run.
                    armed          = 1'b0;
                    running        = 1'b1;
                    baseline_pins  = mp;
                    taken          = '0;
                    cause          = CAUSE_NONE;
                    last_edge_tick = now;
                    queue_result(RES_STARTED, now, mp, '0);
                end
                else if (running && mp != baseline_pins)
                begin
                    idx            = taken;
                    taken          = taken + COUNT_W'(1);
                    baseline_pins  = mp;
                    last_edge_tick = now;
                    if (int'(idx) + 1 >= int'(effective_limit()))
                    begin
                        running = 1'b0;
                        cause   = CAUSE_LIMIT;
                        queue_result(RES_EDGE, now, mp, idx);
                        queue_result(RES_STOPPED, last_edge_tick, mp, taken);
                    end
                    else
                    begin
                        queue_result(RES_EDGE, now, mp, idx);
                    end
                end
            end
            KIND_ARM:
            begin
                if (armed || running)
                begin
                    queue_result(RES_REJECTED, now, mp, taken);
                end
                else
                begin
                    taken = '0;
                    cause = CAUSE_NONE;
                    armed = 1'b1;
                    queue_result(RES_ACCEPTED, now, mp, taken);
                end
            end
            KIND_HOST_STOP, KIND_FORCE_SAFE:
            begin
                // When only armed, force safe just disarms while a host stop also reports the stop.
                if (armed)
                begin
                    armed = 1'b0;
                    if (k == KIND_HOST_STOP)
                    begin
                        cause   = CAUSE_HOST;
                        stopped = 1'b1;
                    end
                end
                if (running)
                begin
                    running = 1'b0;
                    cause   = (k == KIND_HOST_STOP) ? CAUSE_HOST : CAUSE_FORCE;
                    stopped = 1'b1;
                end
                if (stopped)
                    queue_result(RES_STOPPED, now, mp, taken);
                queue_result(RES_ACCEPTED, now, mp, taken);
            end
            KIND_CLEAR:
            begin
                if (armed || running)
                begin
                    queue_result(RES_REJECTED, now, mp, taken);
                end
                else
                begin
                    generation     = generation + 1;
                    taken          = '0;
                    baseline_pins  = mp;
                    cause          = CAUSE_NONE;
                    last_edge_tick = '0;
                    queue_result(RES_ACCEPTED, now, mp, taken);
                end
            end
            default:
            begin
                // Undefined kinds are dropped without touching the tick.
            end
        endcase
        if (awaited_results.size() > before_size)
            awaited_results[awaited_results.size() - 1].last = 1'b1;
    endtask

    // Compares one delivered result with the oldest prediction.
    task automatic check_result();
        result_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch($sformatf("result %0d (kind %0d) arrived with nothing expected",
                                      n_results, out_mon.result_kind));
        end
        else
        begin
            want = awaited_results.pop_front();
            compare_field("last", 32'(out_mon.last), 32'(want.last));
            compare_field("result_kind", 32'(out_mon.result_kind), 32'(want.result_kind));
            compare_field("timestamp", out_mon.timestamp, want.timestamp);
            compare_field("masked_pins", 32'(out_mon.masked_pins), 32'(want.masked_pins));
            compare_field("record_count", 32'(out_mon.record_count),
                          32'(want.record_count));
            compare_field("stop_cause", 32'(out_mon.stop_cause), 32'(want.stop_cause));
            compare_field("busy_res", 32'(out_mon.busy_res), 32'(want.busy_res));
            compare_field("generation_number", out_mon.generation_number,
                          want.generation_number);
        end
        if (out_mon.result_kind == RES_EDGE)
            n_edges++;
        if (out_mon.result_kind == RES_STOPPED && out_mon.stop_cause == CAUSE_LIMIT)
            n_limit_stops++;
        n_results++;
    endtask

    // Everything is sampled at the clock edge; the outputs change by nonblocking update.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      = LIMIT_RESET;
            mask_reg       = MASK_RESET;
            read_expect    = '0;
            tick           = '0;
            baseline_pins  = '0;
            taken          = '0;
            running        = 1'b0;
            armed          = 1'b0;
            cause          = CAUSE_NONE;
            last_edge_tick = '0;
            generation     = 1;
            awaited_results.delete();
            errors         = 0;
            n_items        = 0;
            n_results      = 0;
            n_edges        = 0;
            n_limit_stops  = 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
                check_result();
            // Register reads must return the value last written.
            if (psel && penable && !pwrite && pready)
            begin
                if (reg_idx_t'(paddr[2]) == REG_EDGE_QUOTA)
                    read_expect = APB_DW'(limit_reg);
                else
                    read_expect = APB_DW'(mask_reg);
                if (prdata !== read_expect)
                    report_mismatch($sformatf("register read 0x%0h: got 0x%0h, expected 0x%0h",
                                              paddr, prdata, read_expect));
            end
            if (psel && penable && pwrite && pready)
            begin
                if (reg_idx_t'(paddr[2]) == REG_EDGE_QUOTA)
                    limit_reg = pwdata[COUNT_W-1:0];
                else
                    mask_reg = pwdata[PIN_W-1:0];
            end
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.kind <= KIND_CLEAR)
                    n_items++;
                advance_capture(in_mon.kind, in_mon.pins);
            end
        end
        fail_count   <= errors;
        pending      <= awaited_results.size();
        items_seen   <= n_items;
        results_seen <= n_results;
        edges_seen   <= n_edges;
        limit_stops  <= n_limit_stops;
    end

endmodule

// ===== bench/pin_change_timestamp_capture_tb.sv =====
`timescale 1ns / 100ps

module pin_change_timestamp_capture_tb import pctc_pkg::*; ();

    localparam int IDLE_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    pctc_in_if  in_ch ();
    pctc_out_if out_ch ();

    int fail_count;
    int pending;
    int items_seen;
    int results_seen;
    int edges_seen;
    int limit_stops;

    // Stimulus bookkeeping.
    int               items_sent;
    logic [PIN_W-1:0] cur_pins;
    bit               steady;
    bit               calm_phase;

    pin_change_timestamp_capture u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    pctc_capture_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .items_seen   (items_seen),
        .results_seen (results_seen),
        .edges_seen   (edges_seen),
        .limit_stops  (limit_stops)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Presents one item, after a random gap unless steady, and returns once it is taken.
    task automatic send_item(input logic [KIND_W-1:0] k, input logic [PIN_W-1:0] p);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= k;
        in_ch.pins  <= p;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (k <= KIND_CLEAR)
            items_sent++;
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_read(input reg_idx_t idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Lets every result drain, waits out items that give none, then reprograms.
    task automatic reconfigure(input logic [COUNT_W-1:0] lim, input logic [PIN_W-1:0] mask);
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        reg_write(REG_EDGE_QUOTA, APB_DW'(lim));
        reg_write(REG_PIN_SELECT, APB_DW'(mask));
        reg_read(REG_EDGE_QUOTA);
        reg_read(REG_PIN_SELECT);
    endtask

    function automatic logic [PIN_W-1:0] next_pins(input logic [PIN_W-1:0] p);
        case ($urandom_range(0, 3))
            0: return p;
            1: return p ^ (PIN_W'(1) << $urandom_range(0, PIN_W - 1));
            2: return p ^ PIN_W'($urandom);
            default: return PIN_W'($urandom);
        endcase
    endfunction

    // One armed run with random pin activity, the odd stray item, and a random ending.
    task automatic run_capture(input int len);
        int step;
        steady = calm_phase || ($urandom_range(0, 4) == 0);
        send_item(KIND_ARM, PIN_W'($urandom));
        for (step = 0; step < len; step++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_item(KIND_W'($urandom_range(0, 7)), PIN_W'($urandom));
            end
            else
            begin
                cur_pins = next_pins(cur_pins);
                send_item(KIND_SAMPLE, cur_pins);
            end
        end
        case ($urandom_range(0, 4))
            0: send_item(KIND_HOST_STOP, PIN_W'($urandom));
            1: send_item(KIND_FORCE_SAFE, PIN_W'($urandom));
            2: send_item(KIND_CLEAR, PIN_W'($urandom));
            default: ;
        endcase
    endtask

    task automatic random_runs(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target)
            run_capture($urandom_range(1, 30));
    endtask

    // Result side: random stalls, with stretches of none.
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    // Ends the run if nothing moves on any port for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_ch.valid <= 1'b0;
        in_ch.kind  <= KIND_SAMPLE;
        in_ch.pins  <= '0;
        items_sent  = 0;
        cur_pins    = '0;
        steady      = 1'b0;
        calm_phase  = 1'b0;
        rst_n       = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Commands while idle, stray kinds, and rejection while busy.
        send_item(KIND_SAMPLE, 16'hFFFF);
        send_item(KIND_SAMPLE, 16'h0000);
        send_item(KIND_FORCE_SAFE, 16'hFFFF);
        send_item(KIND_HOST_STOP, 16'h0000);
        send_item(3'd5, 16'h1234);
        send_item(3'd6, 16'hFFFF);
        send_item(3'd7, 16'h0000);
        send_item(KIND_CLEAR, 16'hA5A5);
        send_item(KIND_ARM, 16'h0000);
        send_item(KIND_ARM, 16'hFFFF);
        send_item(KIND_CLEAR, 16'h0000);
        send_item(KIND_HOST_STOP, 16'hFFFF);
        send_item(KIND_ARM, 16'h0000);
        send_item(KIND_FORCE_SAFE, 16'hFFFF);

        // A run under the reset mask: baseline, edges, an unmasked pin, stop by host.
        send_item(KIND_ARM, 16'h0000);
        send_item(KIND_SAMPLE, 16'hFFFF);
        send_item(KIND_SAMPLE, 16'h0000);
        send_item(KIND_SAMPLE, 16'h0001);
        send_item(KIND_ARM, 16'h0000);
        send_item(KIND_CLEAR, 16'hFFFF);
        send_item(KIND_SAMPLE, 16'hFFFF);
        send_item(KIND_HOST_STOP, 16'h0F0F);

        // A run ended by force safe, then a clear.
        send_item(KIND_ARM, 16'h0000);
        send_item(KIND_SAMPLE, 16'h4000);
        send_item(KIND_FORCE_SAFE, 16'h8000);
        send_item(KIND_CLEAR, 16'hFFFF);

        // Limit of one: the first edge also stops the run.
        reconfigure(11'd1, 16'hFFFF);
        send_item(KIND_ARM, 16'h0000);
        send_item(KIND_SAMPLE, 16'h1234);
        send_item(KIND_SAMPLE, 16'h1235);
        send_item(KIND_SAMPLE, 16'h0000);
        random_runs(120);

        // Zero limit acting as one, a single live pin, and no idling at all.
        reconfigure(11'd0, 16'h0001);
        calm_phase = 1'b1;
        random_runs(120);
        calm_phase = 1'b0;

        // Largest limit register value: a run that fills the whole capacity.
        reconfigure(11'd2047, 16'hFFFF);
        steady = 1'b0;
        send_item(KIND_ARM, 16'h0000);
        cur_pins = '0;
        repeat (CAPACITY + 2)
        begin
            cur_pins = ~cur_pins;
            send_item(KIND_SAMPLE, cur_pins);
        end

        // Empty mask: runs start and stop but never see an edge.
        reconfigure(11'd1024, 16'h0000);
        random_runs(80);

        // Small random limits with random masks.
        repeat (3)
        begin
            reconfigure(COUNT_W'($urandom_range(2, 12)), PIN_W'($urandom));
            random_runs(50);
        end

        // Drain and give the verdict.
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
        $display("Covered %0d items and %0d results, %0d of them edge records.",
                 items_seen, results_seen, edges_seen);
        $display("Event limits 0, 1, 1024, 2047 and random; %0d runs ended at the limit.",
                 limit_stops);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
